>>> design/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// shared types and constants of the stack machine execute core
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned WordW = 32;
  localparam int unsigned LimitW = 11;

  typedef enum logic [4:0] {
    OP_NOP    = 5'd0,
    OP_C32    = 5'd1,
    OP_C64    = 5'd2,
    OP_DROP   = 5'd3,
    OP_ADD    = 5'd4,
    OP_SUB    = 5'd5,
    OP_MUL    = 5'd6,
    OP_DIVS   = 5'd7,
    OP_AND    = 5'd8,
    OP_OR     = 5'd9,
    OP_XOR    = 5'd10,
    OP_EQ     = 5'd11,
    OP_NE     = 5'd12,
    OP_LTS    = 5'd13,
    OP_BR     = 5'd14,
    OP_BRIF   = 5'd15,
    OP_RET    = 5'd16,
    OP_CALL   = 5'd17,
    OP_CLRERR = 5'd18
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BRANCH = 2'd1,
    ST_RETURN = 2'd2,
    ST_ERROR  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_INVALID   = 3'd3,
    ERR_DIVZERO   = 3'd4,
    ERR_CALL      = 3'd5
  } error_t;

  typedef enum logic [0:0] {
    CFG_STACK_LIMIT      = 1'd0,
    CFG_MODULE_AVAILABLE = 1'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3,
    S_DIV,
    S_EXEC,
    S_PUSH2
  } state_t;

endpackage

>>> design/smx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_in_if / smx_out_if
// instruction and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface smx_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [63:0] operand_value;
  logic        has_operand;

  modport source (output valid, output opcode, output operand_value,
                  output has_operand, input ready);
  modport sink (input valid, input opcode, input operand_value,
                input has_operand, output ready);
endinterface

interface smx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  fault_code;
  logic [10:0] stack_depth;
  logic [31:0] top_value;
  logic [63:0] executed_count;
  logic [63:0] call_count;

  modport source (output valid, output status, output fault_code,
                  output stack_depth, output top_value, output executed_count,
                  output call_count, input ready);
  modport sink (input valid, input status, input fault_code,
                input stack_depth, input top_value, input executed_count,
                input call_count, output ready);
endinterface

>>> design/stack_machine_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// executes one stack machine instruction per transaction on a word stack
// sequence: accept, stack reads in S_RD1 to S_RD3, S_DIV while the divider runs,
// then S_EXEC, which waits while the previous result waits for ready, and
// S_PUSH2 for c64; a new instruction is accepted only back in S_IDLE, so
// issue is paced by two reads of the stack memory and the bit-serial divider
// reset: synchronous, clears stack pointer, error, counters and handshake
// ----------------------------------------------------------------------------
module stack_machine_execute_core #(
  parameter int unsigned StackDepth = smx_pkg::StackDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [smx_pkg::LimitW-1:0]  cfg_data,
  smx_in_if.sink                      in_ch,
  smx_out_if.source                   out_ch
);

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned W = smx_pkg::WordW;

  smx_pkg::state_t state, state_next;

  logic [SpW-1:0]  sp, sp_next;
  logic [W-1:0]    top, top_next;
  logic [2:0]      err, err_next;
  logic [63:0]     icnt, icnt_next;
  logic [63:0]     ccnt, ccnt_next;
  logic [smx_pkg::LimitW-1:0] limit;
  logic            avail;
  logic [4:0]      op;
  logic [63:0]     val;
  logic            has;
  logic [W-1:0]    s2;
  logic [W-1:0]    s3;

  logic            out_valid;
  logic [1:0]      out_status;
  logic [2:0]      out_error;
  logic [10:0]     out_depth;
  logic [W-1:0]    out_top;
  logic [63:0]     out_icnt;
  logic [63:0]     out_ccnt;

  logic            mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [W-1:0]    mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [W-1:0]    mem_rdata;

  logic            div_start;
  logic            div_done;
  logic [W-1:0]    div_q;

  logic            go;
  logic            emit;
  logic [1:0]      st;
  logic [31:0]     lim32;
  logic [SpW-1:0]  sp2;
  logic [SpW-1:0]  sp3;
  logic            full_sp;
  logic            full_sp2;
  logic [W-1:0]    top_pop2;
  logic [W-1:0]    alu;
  logic [W-1:0]    prod;

  smx_stack_mem #(.Depth(StackDepth), .AddrW(AddrW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  smx_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s2),
    .divisor  (top),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ch.ready = (state == smx_pkg::S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.fault_code = out_error;
  assign out_ch.stack_depth = out_depth;
  assign out_ch.top_value = out_top;
  assign out_ch.executed_count = out_icnt;
  assign out_ch.call_count = out_ccnt;

  assign go = !out_valid || out_ch.ready;
  assign lim32 = (limit == '0 || 32'(limit) > 32'(StackDepth)) ? 32'(StackDepth)
                                                               : 32'(limit);
  assign sp2 = sp - SpW'(2);
  assign sp3 = sp - SpW'(3);
  assign full_sp = 32'(sp) >= lim32;
  assign full_sp2 = 32'(sp2) >= lim32;
  assign top_pop2 = (sp >= SpW'(3)) ? s3 : '0;
  assign prod = s2 * top;

  assign div_start = (state == smx_pkg::S_RD3) && (op == smx_pkg::OP_DIVS) &&
                     (sp >= SpW'(2)) && (err == smx_pkg::ERR_NONE) && (top != '0);

  always_comb begin
    case (op)
      smx_pkg::OP_ADD:  alu = s2 + top;
      smx_pkg::OP_SUB:  alu = s2 - top;
      smx_pkg::OP_MUL:  alu = prod;
      smx_pkg::OP_DIVS: alu = div_q;
      smx_pkg::OP_AND:  alu = s2 & top;
      smx_pkg::OP_OR:   alu = s2 | top;
      smx_pkg::OP_XOR:  alu = s2 ^ top;
      smx_pkg::OP_EQ:   alu = W'(s2 == top);
      smx_pkg::OP_NE:   alu = W'(s2 != top);
      default:          alu = W'($signed(s2) < $signed(top));
    endcase
  end

  always_comb begin
    case (state)
      smx_pkg::S_RD1: mem_raddr = sp2[AddrW-1:0];
      default:        mem_raddr = sp3[AddrW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    sp_next = sp;
    top_next = top;
    err_next = err;
    icnt_next = icnt;
    ccnt_next = ccnt;
    mem_we = 1'b0;
    mem_waddr = sp[AddrW-1:0];
    mem_wdata = val[W-1:0];
    emit = 1'b0;
    st = smx_pkg::ST_OK;
    case (state)
      smx_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_next = smx_pkg::S_RD1;
        end
      end
      smx_pkg::S_RD1: state_next = smx_pkg::S_RD2;
      smx_pkg::S_RD2: state_next = smx_pkg::S_RD3;
      smx_pkg::S_RD3: state_next = div_start ? smx_pkg::S_DIV : smx_pkg::S_EXEC;
      smx_pkg::S_DIV: begin
        if (div_done) begin
          state_next = smx_pkg::S_EXEC;
        end
      end
      smx_pkg::S_EXEC: begin
        if (go) begin
          emit = 1'b1;
          state_next = smx_pkg::S_IDLE;
          if (op != smx_pkg::OP_CLRERR) begin
            icnt_next = icnt + 64'd1;
          end
          case (op)
            smx_pkg::OP_CLRERR: err_next = smx_pkg::ERR_NONE;
            smx_pkg::OP_NOP: st = smx_pkg::ST_OK;
            smx_pkg::OP_C32, smx_pkg::OP_C64: begin
              if (has) begin
                if (full_sp) begin
                  err_next = smx_pkg::ERR_OVERFLOW;
                  st = smx_pkg::ST_ERROR;
                end else begin
                  mem_we = 1'b1;
                  sp_next = sp + SpW'(1);
                  top_next = val[W-1:0];
                  if (op == smx_pkg::OP_C64) begin
                    emit = 1'b0;
                    state_next = smx_pkg::S_PUSH2;
                  end
                end
              end
            end
            smx_pkg::OP_DROP, smx_pkg::OP_BRIF: begin
              if (sp == '0) begin
                err_next = smx_pkg::ERR_UNDERFLOW;
              end else begin
                sp_next = sp - SpW'(1);
                top_next = (sp >= SpW'(2)) ? s2 : '0;
              end
              if (err_next != smx_pkg::ERR_NONE) begin
                st = smx_pkg::ST_ERROR;
              end else if (op == smx_pkg::OP_BRIF && top != '0) begin
                st = smx_pkg::ST_BRANCH;
              end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIVS,
            smx_pkg::OP_AND, smx_pkg::OP_OR, smx_pkg::OP_XOR, smx_pkg::OP_EQ,
            smx_pkg::OP_NE, smx_pkg::OP_LTS: begin
              st = smx_pkg::ST_ERROR;
              if (sp < SpW'(2)) begin
                err_next = smx_pkg::ERR_UNDERFLOW;
                sp_next = '0;
                top_next = '0;
              end else begin
                sp_next = sp2;
                top_next = top_pop2;
                if (err != smx_pkg::ERR_NONE) begin
                  st = smx_pkg::ST_ERROR;
                end else if (op == smx_pkg::OP_DIVS && top == '0) begin
                  err_next = smx_pkg::ERR_DIVZERO;
                end else if (full_sp2) begin
                  err_next = smx_pkg::ERR_OVERFLOW;
                end else begin
                  st = smx_pkg::ST_OK;
                  mem_we = 1'b1;
                  mem_waddr = sp2[AddrW-1:0];
                  mem_wdata = alu;
                  sp_next = sp2 + SpW'(1);
                  top_next = alu;
                end
              end
            end
            smx_pkg::OP_BR: st = smx_pkg::ST_BRANCH;
            smx_pkg::OP_RET: st = smx_pkg::ST_RETURN;
            smx_pkg::OP_CALL: begin
              if (avail) begin
                ccnt_next = ccnt + 64'd1;
              end else begin
                err_next = smx_pkg::ERR_CALL;
                st = smx_pkg::ST_ERROR;
              end
            end
            default: begin
              err_next = smx_pkg::ERR_INVALID;
              st = smx_pkg::ST_ERROR;
            end
          endcase
        end
      end
      smx_pkg::S_PUSH2: begin
        if (go) begin
          emit = 1'b1;
          state_next = smx_pkg::S_IDLE;
          if (full_sp) begin
            err_next = smx_pkg::ERR_OVERFLOW;
            st = smx_pkg::ST_ERROR;
          end else begin
            mem_we = 1'b1;
            mem_wdata = val[63:W];
            sp_next = sp + SpW'(1);
            top_next = val[63:W];
          end
        end
      end
      default: state_next = smx_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smx_pkg::S_IDLE;
      sp <= '0;
      top <= '0;
      err <= smx_pkg::ERR_NONE;
      icnt <= '0;
      ccnt <= '0;
      limit <= smx_pkg::LimitW'(1024);
      avail <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp <= sp_next;
      top <= top_next;
      err <= err_next;
      icnt <= icnt_next;
      ccnt <= ccnt_next;
      if (cfg_we) begin
        case (cfg_index)
          smx_pkg::CFG_STACK_LIMIT:      limit <= cfg_data;
          smx_pkg::CFG_MODULE_AVAILABLE: avail <= cfg_data[0];
          default:                       avail <= avail;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == smx_pkg::S_IDLE && in_ch.valid) begin
      op <= in_ch.opcode;
      val <= in_ch.operand_value;
      has <= in_ch.has_operand;
    end
    if (state == smx_pkg::S_RD2) begin
      s2 <= mem_rdata;
    end
    if (state == smx_pkg::S_RD3) begin
      s3 <= mem_rdata;
    end
    if (emit) begin
      out_status <= st;
      out_error <= err_next;
      out_depth <= 11'(sp_next);
      out_top <= top_next;
      out_icnt <= icnt_next;
      out_ccnt <= ccnt_next;
    end
  end

endmodule

>>> design/smx_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_stack_mem
// stack word memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module smx_stack_mem #(
  parameter int unsigned Depth = smx_pkg::StackDepthDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AddrW-1:0]           waddr,
  input  logic [smx_pkg::WordW-1:0]  wdata,
  input  logic [AddrW-1:0]           raddr,
  output logic [smx_pkg::WordW-1:0]  rdata
);

  logic [smx_pkg::WordW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/smx_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_divider
// signed 32-bit divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smx_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [smx_pkg::WordW-1:0] dividend,
  input  logic [smx_pkg::WordW-1:0] divisor,
  output logic                      done,
  output logic [smx_pkg::WordW-1:0] quotient
);

  localparam int unsigned W = smx_pkg::WordW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    dvd;
  logic [W-1:0]    dsr;
  logic [W:0]      rem;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [W:0]      rem_sh;
  logic            fits;

  assign rem_sh = {rem[W-1:0], dvd[W-1]};
  assign fits = rem_sh >= {1'b0, dsr};
  assign quotient = neg ? (W'(0) - dvd) : dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(W);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      dsr <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg <= dividend[W-1] ^ divisor[W-1];
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
      dvd <= {dvd[W-2:0], fits};
    end
  end

endmodule
